// ===== hw/rtl/cfrc_pkg.sv =====
// shared types, constants and the crc-32 byte update for the record checker
// no dependencies
package cfrc_pkg;

  localparam int unsigned CountW   = 17;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CountW-1:0] HdrBytes   = CountW'(20);
  localparam logic [CountW-1:0] HdrCrcSpan = CountW'(16);
  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [31:0]       CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0]       CrcInit    = 32'hFFFF_FFFF;
  localparam logic [15:0]       VersionRst = 16'd1;

  typedef enum logic [0:0] {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_HCRC    = 3'd3,
    ST_VERSION = 3'd4,
    ST_LENGTH  = 3'd5,
    ST_PCRC    = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rec_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        record_done;
    logic [2:0]  status;
    logic [15:0] record_version;
    logic [15:0] payload_length;
    logic [31:0] source_address;
    logic [31:0] stored_payload_crc;
  } rec_out_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
  } cfg_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cfrc_stream_if.sv =====
// valid/ready stream channel with a typed payload
// no dependencies
interface cfrc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cfrc_csr.sv =====
// apb configuration registers: expected magic and expected version
// depends on cfrc_pkg
module cfrc_csr (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfrc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [cfrc_pkg::ApbDataW-1:0]  pwdata,
  output logic [cfrc_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output cfrc_pkg::cfg_t                 cfg_o
);
  import cfrc_pkg::*;

  logic [31:0] magic_q;
  logic [15:0] version_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= VersionRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAGIC:   magic_q   <= pwdata[31:0];
        REG_VERSION: version_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC:   prdata = magic_q;
      REG_VERSION: prdata = {16'd0, version_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = '{expected_magic: magic_q, expected_version: version_q};

endmodule

// ===== hw/rtl/crc_framed_record_checker_unit.sv =====
// crc-framed record checker top level: header capture, running crc, status
// depends on cfrc_pkg, cfrc_stream_if, cfrc_csr
//
// channel   dir  handshake      payload
// rec_in_i  in   valid/ready    data_byte, last_byte
// rec_out_o out  valid/ready    passed byte, payload flag, status, header fields
// apb       in   psel/penable   expected_magic @0x0, expected_version @0x4
//
// one byte per cycle unless the result stalls; each result shows in the cycle after its byte; the
// byte-wide crc xor network feeds the result register directly
// async active-low reset clears the record state and the result valid flag
// a stalled result holds; a new byte is taken in the cycle the result leaves
module crc_framed_record_checker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cfrc_stream_if.sink                    rec_in_i,
  cfrc_stream_if.source                  rec_out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfrc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [cfrc_pkg::ApbDataW-1:0]  pwdata,
  output logic [cfrc_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import cfrc_pkg::*;

  cfg_t cfg;

  cfrc_csr u_csr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       crc_q, crc_d, hcrc_q, hcrc_d;
  logic [31:0]       magic_q, magic_d, addr_q, addr_d, pcrc_q, pcrc_d, hchk_q, hchk_d;
  logic [15:0]       version_q, version_d, length_q, length_d;

  rec_out_t out_q, out_d;
  logic     out_valid_q;
  logic     in_xfer;
  logic [7:0]  b;
  logic [1:0]  lane;
  logic        pay;
  logic [31:0] crc_upd;
  status_e     st;

  assign rec_in_i.ready  = !out_valid_q || rec_out_o.ready;
  assign in_xfer         = rec_in_i.valid && rec_in_i.ready;
  assign rec_out_o.valid = out_valid_q;
  assign rec_out_o.payload = out_q;

  assign b       = rec_in_i.payload.data_byte;
  assign lane    = count_q[1:0];
  assign crc_upd = crc_byte(crc_q, b);

  always_comb begin
    magic_d   = magic_q;
    version_d = version_q;
    length_d  = length_q;
    addr_d    = addr_q;
    pcrc_d    = pcrc_q;
    hchk_d    = hchk_q;
    pay       = 1'b0;
    priority if (count_q < CountW'(4)) begin
      magic_d[8*lane +: 8] = b;
    end else if (count_q < CountW'(6)) begin
      version_d[8*lane[0] +: 8] = b;
    end else if (count_q < CountW'(8)) begin
      length_d[8*lane[0] +: 8] = b;
    end else if (count_q < CountW'(12)) begin
      addr_d[8*lane +: 8] = b;
    end else if (count_q < HdrCrcSpan) begin
      pcrc_d[8*lane +: 8] = b;
    end else if (count_q < HdrBytes) begin
      hchk_d[8*lane +: 8] = b;
    end else if ((count_q - HdrBytes) < {1'b0, length_q}) begin
      pay = 1'b1;
    end else begin
      pay = 1'b0;
    end

    crc_d  = crc_q;
    hcrc_d = hcrc_q;
    if (count_q < HdrCrcSpan) begin
      crc_d = crc_upd;
      if (count_q == HdrCrcSpan - CountW'(1)) begin
        hcrc_d = ~crc_upd;
        crc_d  = CrcInit;
      end
    end else if (pay) begin
      crc_d = crc_upd;
    end

    count_d = (count_q == CountMax) ? count_q : count_q + CountW'(1);

    priority if (count_d < HdrBytes)                          st = ST_TRUNC;
    else if (magic_d != cfg.expected_magic)                    st = ST_MAGIC;
    else if (hcrc_d != hchk_d)                                 st = ST_HCRC;
    else if (version_d != cfg.expected_version)                st = ST_VERSION;
    else if (length_d == 16'd0)                                st = ST_LENGTH;
    else if ((HdrBytes + {1'b0, length_d}) > count_d)          st = ST_LENGTH;
    else if (~crc_d != pcrc_d)                                 st = ST_PCRC;
    else                                                       st = ST_OK;

    out_d = '0;
    out_d.payload_byte = b;
    out_d.is_payload   = pay;
    if (rec_in_i.payload.last_byte) begin
      out_d.record_done        = 1'b1;
      out_d.status             = st;
      out_d.record_version     = version_d;
      out_d.payload_length     = length_d;
      out_d.source_address     = addr_d;
      out_d.stored_payload_crc = pcrc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= CrcInit;
      hcrc_q    <= '0;
      magic_q   <= '0;
      version_q <= '0;
      length_q  <= '0;
      addr_q    <= '0;
      pcrc_q    <= '0;
      hchk_q    <= '0;
    end else if (in_xfer) begin
      if (rec_in_i.payload.last_byte) begin
        count_q   <= '0;
        crc_q     <= CrcInit;
        hcrc_q    <= '0;
        magic_q   <= '0;
        version_q <= '0;
        length_q  <= '0;
        addr_q    <= '0;
        pcrc_q    <= '0;
        hchk_q    <= '0;
      end else begin
        count_q   <= count_d;
        crc_q     <= crc_d;
        hcrc_q    <= hcrc_d;
        magic_q   <= magic_d;
        version_q <= version_d;
        length_q  <= length_d;
        addr_q    <= addr_d;
        pcrc_q    <= pcrc_d;
        hchk_q    <= hchk_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (rec_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/cfrc_checker.sv =====
// port-level assertions for the record checker, bound to the top level
// depends on cfrc_pkg and crc_framed_record_checker_unit
module cfrc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input cfrc_pkg::rec_out_t out_payload_i
);
  import cfrc_pkg::*;

  // an accepted byte always shows up as a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte gave no result");

  // header fields and status are zero except on the final byte
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_payload_i.record_done |->
      out_payload_i.status == ST_OK && out_payload_i.record_version == 16'd0 &&
      out_payload_i.payload_length == 16'd0 && out_payload_i.source_address == 32'd0 &&
      out_payload_i.stored_payload_crc == 32'd0)
    else $error("header fields on a non-final byte");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.status != 3'd7)
    else $error("undefined status code");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result changed");

endmodule

bind crc_framed_record_checker_unit cfrc_checker u_cfrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (rec_in_i.valid),
  .in_ready_i    (rec_in_i.ready),
  .out_valid_i   (rec_out_o.valid),
  .out_ready_i   (rec_out_o.ready),
  .out_payload_i (rec_out_o.payload)
);

// ===== bench/crc_framed_record_checker_unit_tb.sv =====
// testbench for the crc-framed record checker: builds stored records with and without
// flaws, predicts the result of every byte and checks each result field by field
// depends on cfrc_pkg, cfrc_stream_if and crc_framed_record_checker_unit
module crc_framed_record_checker_unit_tb;
  import cfrc_pkg::*;

  typedef enum int {
    FL_NONE, FL_TRUNC, FL_MAGIC, FL_HCRC, FL_VERSION, FL_ZERO_LEN, FL_SHORT, FL_PCRC, FL_NOISE
  } flaw_e;

  class record_tracker;
    localparam int HDR_LEN  = 20;
    localparam int CRC_SPAN = 16;
    localparam int POS_MAX  = 131071;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    logic [31:0] exp_magic;
    logic [15:0] exp_version;
    int          rec_pos;
    logic [31:0] crc_acc;
    logic [31:0] hdr_crc_calc;
    logic [31:0] cap_magic;
    logic [15:0] cap_version;
    logic [15:0] cap_length;
    logic [31:0] cap_addr;
    logic [31:0] cap_pcrc;
    logic [31:0] cap_hcrc;
    rec_out_t    byte_results_due[$];
    int          errors;

    function new();
      exp_magic   = '0;
      exp_version = 16'd1;
      errors      = 0;
      clear_record();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void clear_record();
      rec_pos      = 0;
      crc_acc      = '1;
      hdr_crc_calc = '0;
      cap_magic    = '0;
      cap_version  = '0;
      cap_length   = '0;
      cap_addr     = '0;
      cap_pcrc     = '0;
      cap_hcrc     = '0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_MAGIC) exp_magic = value;
      else exp_version = value[15:0];
    endfunction

    function int pending();
      return byte_results_due.size();
    endfunction

    // accepted input byte: update the record state and queue its result
    function void take_byte(rec_in_t item);
      int       p;
      int       count;
      bit       pay;
      status_e  st;
      rec_out_t r;
      p   = rec_pos;
      pay = 1'b0;
      r   = '0;
      if (p < 4) cap_magic[8*p +: 8] = item.data_byte;
      else if (p < 6) cap_version[8*(p-4) +: 8] = item.data_byte;
      else if (p < 8) cap_length[8*(p-6) +: 8] = item.data_byte;
      else if (p < 12) cap_addr[8*(p-8) +: 8] = item.data_byte;
      else if (p < 16) cap_pcrc[8*(p-12) +: 8] = item.data_byte;
      else if (p < HDR_LEN) cap_hcrc[8*(p-16) +: 8] = item.data_byte;
      else pay = (p - HDR_LEN) < int'(cap_length);

      if (p < CRC_SPAN) begin
        crc_acc = crc_step(crc_acc, item.data_byte);
        if (p == CRC_SPAN - 1) begin
          hdr_crc_calc = ~crc_acc;
          crc_acc      = '1;
        end
      end else if (pay) begin
        crc_acc = crc_step(crc_acc, item.data_byte);
      end

      count   = (p < POS_MAX) ? p + 1 : POS_MAX;
      rec_pos = count;

      r.payload_byte = item.data_byte;
      r.is_payload   = pay;
      if (item.last_byte) begin
        if (count < HDR_LEN) st = ST_TRUNC;
        else if (cap_magic != exp_magic) st = ST_MAGIC;
        else if (hdr_crc_calc != cap_hcrc) st = ST_HCRC;
        else if (cap_version != exp_version) st = ST_VERSION;
        else if (cap_length == 0 || HDR_LEN + int'(cap_length) > count) st = ST_LENGTH;
        else if (~crc_acc != cap_pcrc) st = ST_PCRC;
        else st = ST_OK;
        r.record_done        = 1'b1;
        r.status             = st;
        r.record_version     = cap_version;
        r.payload_length     = cap_length;
        r.source_address     = cap_addr;
        r.stored_payload_crc = cap_pcrc;
        clear_record();
      end
      byte_results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(rec_out_t got);
      rec_out_t want;
      if (byte_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = byte_results_due.pop_front();
      compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      compare_field("is_payload", 32'(want.is_payload), 32'(got.is_payload));
      compare_field("record_done", 32'(want.record_done), 32'(got.record_done));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("record_version", 32'(want.record_version), 32'(got.record_version));
      compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      compare_field("source_address", want.source_address, got.source_address);
      compare_field("stored_payload_crc", want.stored_payload_crc, got.stored_payload_crc);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cfrc_stream_if #(.payload_t(rec_in_t))  rec_in ();
  cfrc_stream_if #(.payload_t(rec_out_t)) rec_out ();

  crc_framed_record_checker_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_in_i  (rec_in),
    .rec_out_o (rec_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  record_tracker sb;
  logic [7:0]    frame_q[$];
  bit            calm;
  bit            hold_request;
  int            rec_no;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("crc_framed_record_checker_unit_tb failed");
    $finish;
  end

  function automatic void push_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) frame_q.push_back(v[8*k +: 8]);
  endfunction

  // lays out one stored record in frame_q, with the given flaw
  function automatic void build_record(flaw_e flaw, int fixed_len, int fixed_trail);
    logic [31:0] magic;
    logic [31:0] pcrc;
    logic [31:0] crc;
    logic [31:0] hcrc;
    logic [15:0] version;
    logic [15:0] length;
    int          n_body;
    int          n_trail;
    int          keep;
    logic [7:0]  body[$];
    magic   = sb.exp_magic;
    version = sb.exp_version;
    frame_q.delete();
    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      return;
    end
    if (fixed_len >= 0) length = 16'(fixed_len);
    else if ($urandom_range(7) == 0) length = 16'($urandom_range(9, 64));
    else length = 16'($urandom_range(1, 8));
    n_body  = int'(length);
    n_trail = (fixed_trail >= 0) ? fixed_trail : $urandom_range(0, 3);
    case (flaw)
      FL_MAGIC: magic = magic ^ ($urandom | 32'd1);
      FL_VERSION: version = version ^ 16'($urandom_range(1, 65535));
      FL_ZERO_LEN: begin
        length = '0;
        n_body = 0;
      end
      FL_SHORT: begin
        length  = 16'($urandom_range(1, 65535));
        n_body  = $urandom_range(0, (length < 9) ? length - 1 : 8);
        n_trail = 0;
      end
      default: ;
    endcase
    crc = '1;
    repeat (n_body) body.push_back(8'($urandom));
    foreach (body[i]) crc = record_tracker::crc_step(crc, body[i]);
    pcrc = ~crc;
    if (flaw == FL_PCRC) pcrc = pcrc ^ ($urandom | 32'd1);
    push_le(magic, 4);
    push_le(32'(version), 2);
    push_le(32'(length), 2);
    push_le($urandom, 4);
    push_le(pcrc, 4);
    crc = '1;
    foreach (frame_q[i]) crc = record_tracker::crc_step(crc, frame_q[i]);
    hcrc = ~crc;
    if (flaw == FL_HCRC) hcrc = hcrc ^ ($urandom | 32'd1);
    push_le(hcrc, 4);
    foreach (body[i]) frame_q.push_back(body[i]);
    repeat (n_trail) frame_q.push_back(8'($urandom));
    if (flaw == FL_TRUNC) begin
      keep = $urandom_range(1, 19);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endfunction

  task automatic push_byte(rec_in_t item);
    if (!calm && $urandom_range(99) < 31) begin
      rec_in.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    rec_in.valid   <= 1'b1;
    rec_in.payload <= item;
    do @(negedge clk_i); while (!rec_in.ready);
    @(posedge clk_i);
    sb.take_byte(item);
  endtask

  task automatic send_frame();
    rec_in_t item;
    foreach (frame_q[i]) begin
      item.data_byte = frame_q[i];
      item.last_byte = (i == frame_q.size() - 1);
      push_byte(item);
    end
  endtask

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    rec_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // half the records well formed, the other half cycle through the flaws
  task automatic run_phase(int budget, bit squeeze);
    int    sent;
    flaw_e flaw;
    sent = 0;
    while (sent < budget) begin
      flaw = (rec_no % 2 == 0) ? FL_NONE : flaw_e'(int'(FL_TRUNC) + (rec_no / 2) % 8);
      rec_no++;
      build_record(flaw, -1, -1);
      if (squeeze && sent == 0) hold_request = 1'b1;
      sent += frame_q.size();
      send_frame();
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int       hold_left;
    bit       fire;
    rec_out_t got;
    rec_out.ready = 1'b0;
    hold_left     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      fire = rec_out.valid && rec_out.ready;
      got  = rec_out.payload;
      @(posedge clk_i);
      if (fire) sb.check_result(got);
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        rec_out.ready <= 1'b0;
        hold_left--;
      end else begin
        rec_out.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin : stimulus
    rec_in_t item;
    rst_ni         = 1'b0;
    rec_in.valid   = 1'b0;
    rec_in.payload = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    hold_request   = 1'b0;
    rec_no         = 0;
    sb             = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte records at the byte extremes, then the shortest good record
    item.data_byte = 8'hFF;
    item.last_byte = 1'b1;
    push_byte(item);
    item.data_byte = 8'h00;
    push_byte(item);
    build_record(FL_NONE, 1, 0);
    send_frame();
    run_phase(100, 1'b0);
    settle();

    write_register(REG_MAGIC, 32'hFFFF_FFFF);
    write_register(REG_VERSION, 32'h0000_FFFF);
    run_phase(110, 1'b1);
    settle();

    write_register(REG_MAGIC, $urandom);
    write_register(REG_VERSION, $urandom);
    calm = 1'b1;
    run_phase(110, 1'b0);
    calm = 1'b0;
    settle();

    write_register(REG_MAGIC, 32'h0000_0000);
    write_register(REG_VERSION, 32'h0000_0000);
    run_phase(110, 1'b0);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("crc_framed_record_checker_unit_tb passed");
    end else begin
      $display("crc_framed_record_checker_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfrc_pkg.sv
hw/rtl/cfrc_stream_if.sv
hw/rtl/cfrc_csr.sv
hw/rtl/crc_framed_record_checker_unit.sv
hw/rtl/cfrc_checker.sv
bench/crc_framed_record_checker_unit_tb.sv
